>>> src/afc_pkg.sv
// shared types, constants and plane table for the box versus frustum cull
`timescale 1ns / 1ps

package afc_pkg;

	localparam int NumRegs   = 8;
	localparam int NumPlanes = 6;
	localparam int NumAxes   = 3;
	localparam int RegW      = 64;
	localparam int AddrW     = 6;
	localparam int IdxW      = 3;
	localparam int CoordW    = 32;
	localparam int CoefW     = CoordW + 1;
	localparam int ProdW     = CoefW + CoordW;
	localparam int DistW     = CoefW + 16;
	localparam int SumW      = ProdW + 2;

	typedef logic [NumRegs-1:0][RegW-1:0] mat_regs_t;
	typedef logic signed [CoordW-1:0] coord_t;
	typedef logic signed [CoefW-1:0] coef_t;
	typedef logic signed [ProdW-1:0] prod_t;
	typedef logic signed [DistW-1:0] dist_t;
	typedef logic signed [SumW-1:0] sum_t;

	typedef struct packed {
		coef_t [NumAxes-1:0] n;
		coef_t               d;
	} plane_t;

	typedef plane_t [NumPlanes-1:0] plane_set_t;

	// col: column paired with column 4, use4: column 4 enters, neg: paired column subtracted
	typedef struct packed {
		logic [1:0] col;
		logic       use4;
		logic       neg;
	} plane_sel_t;

	localparam plane_sel_t PlaneTab [NumPlanes] = '{
		'{col: 2'd0, use4: 1'b1, neg: 1'b0},
		'{col: 2'd0, use4: 1'b1, neg: 1'b1},
		'{col: 2'd1, use4: 1'b1, neg: 1'b0},
		'{col: 2'd1, use4: 1'b1, neg: 1'b1},
		'{col: 2'd2, use4: 1'b0, neg: 1'b0},
		'{col: 2'd2, use4: 1'b1, neg: 1'b1}
	};

	localparam mat_regs_t RegReset = {
		64'h0001_0000_0000_0000,
		64'h0000_0000_0000_0000,
		64'h0000_0000_0001_0000,
		64'h0000_0000_0000_0000,
		64'h0000_0000_0000_0000,
		64'h0001_0000_0000_0000,
		64'h0000_0000_0000_0000,
		64'h0000_0000_0001_0000
	};

endpackage

>>> src/afc_regs.sv
// matrix register file behind the apb-style configuration port
`timescale 1ns / 1ps

module afc_regs (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     psel,
	input  logic                     penable,
	input  logic                     pwrite,
	input  logic [afc_pkg::AddrW-1:0] paddr,
	input  logic [afc_pkg::RegW-1:0]  pwdata,
	output logic [afc_pkg::RegW-1:0]  prdata,
	output logic                     pready,
	output afc_pkg::mat_regs_t       mat
);

	afc_pkg::mat_regs_t          mat_q;
	logic [afc_pkg::IdxW-1:0]    idx;
	logic                        wr_en;

	assign idx    = paddr[afc_pkg::AddrW-1:afc_pkg::AddrW-afc_pkg::IdxW];
	assign pready = 1'b1;
	assign wr_en  = psel & penable & pwrite & pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mat_q <= afc_pkg::RegReset;
		end else if (wr_en) begin
			mat_q[idx] <= pwdata;
		end
	end

	assign prdata = mat_q[idx];
	assign mat    = mat_q;

endmodule

>>> src/afc_planes.sv
// six frustum planes formed from the matrix columns
`timescale 1ns / 1ps

module afc_planes (
	input  afc_pkg::mat_regs_t  mat,
	output afc_pkg::plane_set_t planes
);

	for (genvar gp = 0; gp < afc_pkg::NumPlanes; gp++) begin : g_plane
		localparam int  Ci   = int'(afc_pkg::PlaneTab[gp].col);
		localparam logic Use4 = afc_pkg::PlaneTab[gp].use4;
		localparam logic Neg  = afc_pkg::PlaneTab[gp].neg;

		afc_pkg::coef_t coef [4];

		for (genvar gr = 0; gr < 4; gr++) begin : g_row
			afc_pkg::coord_t e4;
			afc_pkg::coord_t ek;
			afc_pkg::coef_t  t4;
			afc_pkg::coef_t  tk;

			assign e4 = afc_pkg::coord_t'(mat[gr*2+1][63:32]);
			assign ek = afc_pkg::coord_t'(mat[gr*2+Ci/2][(Ci%2)*32 +: 32]);
			assign t4 = Use4 ? afc_pkg::coef_t'(e4) : afc_pkg::coef_t'(0);
			assign tk = Neg ? -afc_pkg::coef_t'(ek) : afc_pkg::coef_t'(ek);
			assign coef[gr] = t4 + tk;
		end

		assign planes[gp].n[0] = coef[0];
		assign planes[gp].n[1] = coef[1];
		assign planes[gp].n[2] = coef[2];
		assign planes[gp].d    = coef[3];
	end

endmodule

>>> src/afc_pipe.sv
// three-stage box test pipeline: input register, products, plane sums and cull flag
`timescale 1ns / 1ps

module afc_pipe (
	input  logic                clk,
	input  logic                arst_n,
	input  afc_pkg::plane_set_t planes,
	input  logic                in_valid,
	output logic                in_ready,
	input  afc_pkg::coord_t     box_min [afc_pkg::NumAxes],
	input  afc_pkg::coord_t     box_max [afc_pkg::NumAxes],
	output logic                out_valid,
	input  logic                out_ready,
	output logic                culled
);

	logic valid_s1, valid_s2, valid_s3;
	logic take_s1, take_s2, take_s3;

	afc_pkg::coord_t box_min_s1 [afc_pkg::NumAxes];
	afc_pkg::coord_t box_max_s1 [afc_pkg::NumAxes];
	afc_pkg::prod_t  prod_s2 [afc_pkg::NumPlanes][afc_pkg::NumAxes];
	afc_pkg::dist_t  dist_s2 [afc_pkg::NumPlanes];
	logic            culled_s3;

	afc_pkg::prod_t  prod [afc_pkg::NumPlanes][afc_pkg::NumAxes];
	afc_pkg::dist_t  dist_sh [afc_pkg::NumPlanes];
	logic [afc_pkg::NumPlanes-1:0] outside;

	assign take_s3  = !valid_s3 || out_ready;
	assign take_s2  = !valid_s2 || take_s3;
	assign take_s1  = !valid_s1 || take_s2;
	assign in_ready = take_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
		end else begin
			if (take_s1) begin
				valid_s1 <= in_valid;
			end
			if (take_s2) begin
				valid_s2 <= valid_s1;
			end
			if (take_s3) begin
				valid_s3 <= valid_s2;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (take_s1 && in_valid) begin
			box_min_s1 <= box_min;
			box_max_s1 <= box_max;
		end
	end

	// test corner per axis: max where the normal is non-negative
	always_comb begin
		for (int p = 0; p < afc_pkg::NumPlanes; p++) begin
			for (int a = 0; a < afc_pkg::NumAxes; a++) begin
				prod[p][a] = afc_pkg::prod_t'(planes[p].n[a]) * afc_pkg::prod_t'(
					planes[p].n[a][afc_pkg::CoefW-1] ? box_min_s1[a] : box_max_s1[a]);
			end
			dist_sh[p] = afc_pkg::dist_t'({planes[p].d, 16'b0});
		end
	end

	always_ff @(posedge clk) begin
		if (take_s2 && valid_s1) begin
			prod_s2 <= prod;
			dist_s2 <= dist_sh;
		end
	end

	always_comb begin
		for (int p = 0; p < afc_pkg::NumPlanes; p++) begin
			afc_pkg::sum_t acc;
			acc = afc_pkg::sum_t'(prod_s2[p][0]) + afc_pkg::sum_t'(prod_s2[p][1])
			    + afc_pkg::sum_t'(prod_s2[p][2]) + afc_pkg::sum_t'(dist_s2[p]);
			outside[p] = acc[afc_pkg::SumW-1];
		end
	end

	always_ff @(posedge clk) begin
		if (take_s3 && valid_s2) begin
			culled_s3 <= |outside;
		end
	end

	assign out_valid = valid_s3;
	assign culled    = culled_s3;

	a_in_to_s1: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> valid_s1)
		else $error("accepted transfer did not reach stage one");

	a_s2_to_s3: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s2 && take_s3 |=> valid_s3)
		else $error("stage two item lost on the way to the output");

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s3 && !out_ready |=> valid_s3 && $stable(culled_s3))
		else $error("stalled result changed");

	a_full_stall: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && valid_s2 && valid_s3 && !out_ready |-> !in_ready)
		else $error("input taken while the pipeline is full and stalled");

endmodule

>>> src/aabb_frustum_cull.sv
// top level of the axis-aligned box versus view frustum cull
//
// boxes arrive on a valid/ready input channel as min and max corners in signed
// q16.16; each transfer yields exactly one culled flag on a valid/ready output
// channel, in order. culled is 1 when the box lies fully outside one of the six
// planes taken from the view-projection matrix.
// the matrix sits in eight 64-bit registers on an apb-style port, register i
// at byte address 8*i; pready is always high and reads return the register.
// a box passes through the input register, the product register and the result
// register, in that order, before its flag is on the output.
// throughput: one box per cycle while out_ready is high; the eighteen 33x32
// multipliers of the product stage work in parallel for every box.
// when the receiver stalls, the result register holds and each stage keeps
// taking items until it is full, so up to three boxes wait in flight before
// in_ready drops.
// reset clears all stage valids and loads the identity matrix; no clearing
// pass is needed.
`timescale 1ns / 1ps

module aabb_frustum_cull (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      psel,
	input  logic                      penable,
	input  logic                      pwrite,
	input  logic [afc_pkg::AddrW-1:0] paddr,
	input  logic [afc_pkg::RegW-1:0]  pwdata,
	output logic [afc_pkg::RegW-1:0]  prdata,
	output logic                      pready,
	input  logic                      in_valid,
	output logic                      in_ready,
	input  logic signed [31:0]        box_min_x,
	input  logic signed [31:0]        box_min_y,
	input  logic signed [31:0]        box_min_z,
	input  logic signed [31:0]        box_max_x,
	input  logic signed [31:0]        box_max_y,
	input  logic signed [31:0]        box_max_z,
	output logic                      out_valid,
	input  logic                      out_ready,
	output logic                      culled
);

	afc_pkg::mat_regs_t  mat;
	afc_pkg::plane_set_t planes;
	afc_pkg::coord_t     box_min [afc_pkg::NumAxes];
	afc_pkg::coord_t     box_max [afc_pkg::NumAxes];

	assign box_min[0] = box_min_x;
	assign box_min[1] = box_min_y;
	assign box_min[2] = box_min_z;
	assign box_max[0] = box_max_x;
	assign box_max[1] = box_max_y;
	assign box_max[2] = box_max_z;

	afc_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.mat     (mat)
	);

	afc_planes u_planes (
		.mat    (mat),
		.planes (planes)
	);

	afc_pipe u_pipe (
		.clk       (clk),
		.arst_n    (arst_n),
		.planes    (planes),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.box_min   (box_min),
		.box_max   (box_max),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.culled    (culled)
	);

endmodule
